>>> rtl/core/three_plane_intersection_unit_defines.svh
// ----------------------------------------------------------------------------
// three plane intersection unit: assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef THREE_PLANE_INTERSECTION_UNIT_DEFINES_SVH
`define THREE_PLANE_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TPI_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpi check failed");

// next-cycle implication, disabled during reset
`define TPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpi check failed");

`endif

>>> rtl/core/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// types and constants of the three plane intersection unit
// ----------------------------------------------------------------------------
package tpi_pkg;

  localparam int CoefBits  = 16;
  localparam int FracBits  = 16;
  localparam int OutBits   = 48;
  // 2x2 minor, row product and full determinant widths
  localparam int MinorBits = 2 * CoefBits + 1;
  localparam int ProdBits  = 3 * CoefBits + 1;
  localparam int DetBits   = 3 * CoefBits + 3;

  typedef struct packed {
    logic [15:0] plane1_a;
    logic [15:0] plane1_b;
    logic [15:0] plane1_c;
    logic [15:0] plane1_d;
    logic [15:0] plane2_a;
    logic [15:0] plane2_b;
    logic [15:0] plane2_c;
    logic [15:0] plane2_d;
    logic [15:0] plane3_a;
    logic [15:0] plane3_b;
    logic [15:0] plane3_c;
    logic [15:0] plane3_d;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [47:0] point_x;
    logic [47:0] point_y;
    logic [47:0] point_z;
    logic        saturated;
  } out_t;

  // word moving down a divider chain
  typedef struct packed {
    logic [DetBits-1:0] rem;
    logic [OutBits-1:0] lo;
    logic [OutBits-1:0] quo;
    logic [DetBits-1:0] dm;
    logic               neg;
    logic               ovf;
  } div_t;

  typedef struct packed {
    logic valid;
    logic found;
  } meta_t;

endpackage

>>> rtl/core/tpi_front.sv
// ----------------------------------------------------------------------------
// tpi_front
// minors, determinant and cramer numerators, divider setup (5 stages)
// ----------------------------------------------------------------------------
module tpi_front #(
  parameter int FRAC_BITS = tpi_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tpi_pkg::in_t  data_i,
  output tpi_pkg::meta_t meta_o,
  output tpi_pkg::div_t div_x_o,
  output tpi_pkg::div_t div_y_o,
  output tpi_pkg::div_t div_z_o
);

  localparam int CB  = tpi_pkg::CoefBits;
  localparam int MW  = tpi_pkg::MinorBits;
  localparam int PW  = tpi_pkg::ProdBits;
  localparam int DW  = tpi_pkg::DetBits;
  localparam int OB  = tpi_pkg::OutBits;
  localparam int DVW = DW + FRAC_BITS + OB;

  logic [3:0] vld_q;

  // stage a: coefficients
  logic signed [CB-1:0] a1_q, b1_q, c1_q, d1_q, a2_q, b2_q, c2_q, d2_q;
  logic signed [CB-1:0] a3_q, b3_q, c3_q, d3_q;
  // stage b: minors
  logic signed [MW-1:0] m1x_q, m2x_q, m3x_q, m1y_q, m2y_q, m3y_q, m1z_q, m2z_q, m3z_q;
  logic signed [CB-1:0] ba1_q, bb1_q, bc1_q, bd1_q, bd2_q, bd3_q;
  // stage c: products
  logic signed [PW-1:0] pd1_q, pd2_q, pd3_q;
  logic signed [PW-1:0] px1_q, px2_q, px3_q, py1_q, py2_q, py3_q, pz1_q, pz2_q, pz3_q;
  // stage d: sums
  logic signed [DW-1:0] det_q, nx_q, ny_q, nz_q;
  // stage e
  logic           meta_valid_q;
  logic           found_q;
  tpi_pkg::div_t  dx_q, dy_q, dz_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      meta_valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q        <= {vld_q[2:0], valid_i};
      meta_valid_q <= vld_q[3];
    end
  end

  // divider setup for one coordinate
  function automatic tpi_pkg::div_t setup(logic signed [DW-1:0] num,
                                          logic signed [DW-1:0] den);
    tpi_pkg::div_t   r;
    logic [DW-1:0]   nm;
    logic [DW-1:0]   dm;
    logic [DVW-1:0]  dvd;
    nm    = num[DW-1] ? DW'(-num) : DW'(num);
    dm    = den[DW-1] ? DW'(-den) : DW'(den);
    dvd   = DVW'(nm) << FRAC_BITS;
    r.dm  = dm;
    r.neg = num[DW-1] ^ den[DW-1];
    r.ovf = (dvd >> OB) >= DVW'(dm);
    r.rem = DW'(dvd >> OB);
    r.lo  = dvd[OB-1:0];
    r.quo = '0;
    return r;
  endfunction

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= data_i.plane1_a[CB-1:0]; b1_q <= data_i.plane1_b[CB-1:0];
      c1_q <= data_i.plane1_c[CB-1:0]; d1_q <= data_i.plane1_d[CB-1:0];
      a2_q <= data_i.plane2_a[CB-1:0]; b2_q <= data_i.plane2_b[CB-1:0];
      c2_q <= data_i.plane2_c[CB-1:0]; d2_q <= data_i.plane2_d[CB-1:0];
      a3_q <= data_i.plane3_a[CB-1:0]; b3_q <= data_i.plane3_b[CB-1:0];
      c3_q <= data_i.plane3_c[CB-1:0]; d3_q <= data_i.plane3_d[CB-1:0];

      m1x_q <= MW'(b2_q * c3_q) - MW'(c2_q * b3_q);
      m2x_q <= MW'(c1_q * b3_q) - MW'(b1_q * c3_q);
      m3x_q <= MW'(b1_q * c2_q) - MW'(c1_q * b2_q);
      m1y_q <= MW'(c2_q * a3_q) - MW'(a2_q * c3_q);
      m2y_q <= MW'(a1_q * c3_q) - MW'(c1_q * a3_q);
      m3y_q <= MW'(c1_q * a2_q) - MW'(a1_q * c2_q);
      m1z_q <= MW'(a2_q * b3_q) - MW'(b2_q * a3_q);
      m2z_q <= MW'(b1_q * a3_q) - MW'(a1_q * b3_q);
      m3z_q <= MW'(a1_q * b2_q) - MW'(b1_q * a2_q);
      ba1_q <= a1_q; bb1_q <= b1_q; bc1_q <= c1_q;
      bd1_q <= d1_q; bd2_q <= d2_q; bd3_q <= d3_q;

      pd1_q <= PW'(ba1_q * m1x_q);
      pd2_q <= PW'(bb1_q * m1y_q);
      pd3_q <= PW'(bc1_q * m1z_q);
      px1_q <= PW'(m1x_q * bd1_q); px2_q <= PW'(m2x_q * bd2_q); px3_q <= PW'(m3x_q * bd3_q);
      py1_q <= PW'(m1y_q * bd1_q); py2_q <= PW'(m2y_q * bd2_q); py3_q <= PW'(m3y_q * bd3_q);
      pz1_q <= PW'(m1z_q * bd1_q); pz2_q <= PW'(m2z_q * bd2_q); pz3_q <= PW'(m3z_q * bd3_q);

      det_q <= DW'(pd1_q) + DW'(pd2_q) + DW'(pd3_q);
      nx_q  <= -(DW'(px1_q) + DW'(px2_q) + DW'(px3_q));
      ny_q  <= -(DW'(py1_q) + DW'(py2_q) + DW'(py3_q));
      nz_q  <= -(DW'(pz1_q) + DW'(pz2_q) + DW'(pz3_q));

      found_q <= (det_q != '0);
      dx_q <= setup(nx_q, det_q);
      dy_q <= setup(ny_q, det_q);
      dz_q <= setup(nz_q, det_q);
    end
  end

  assign meta_o.valid = meta_valid_q;
  assign meta_o.found = found_q;
  assign div_x_o = dx_q;
  assign div_y_o = dy_q;
  assign div_z_o = dz_q;

endmodule

>>> rtl/core/tpi_div_cell.sv
// ----------------------------------------------------------------------------
// tpi_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module tpi_div_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  tpi_pkg::div_t div_i,
  output tpi_pkg::div_t div_o
);

  localparam int DW = tpi_pkg::DetBits;
  localparam int OB = tpi_pkg::OutBits;

  tpi_pkg::div_t div_d, div_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // shift in next dividend bit, compare and subtract
  always_comb begin
    trial = {div_i.rem, div_i.lo[OB-1]};
    diff  = trial - {1'b0, div_i.dm};
    div_d = div_i;
    div_d.lo = {div_i.lo[OB-2:0], 1'b0};
    if (trial >= {1'b0, div_i.dm}) begin
      div_d.rem = diff[DW-1:0];
      div_d.quo = {div_i.quo[OB-2:0], 1'b1};
    end else begin
      div_d.rem = trial[DW-1:0];
      div_d.quo = {div_i.quo[OB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

>>> rtl/core/tpi_div_chain.sv
// ----------------------------------------------------------------------------
// tpi_div_chain
// row of division cells for one coordinate, sign and saturation at the end
// ----------------------------------------------------------------------------
module tpi_div_chain (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  tpi_pkg::div_t               div_i,
  output logic [tpi_pkg::OutBits-1:0] coord_o,
  output logic                        sat_o
);

  localparam int OB = tpi_pkg::OutBits;

  tpi_pkg::div_t  link [OB+1];
  tpi_pkg::div_t  last;
  logic [OB-1:0]  neg_lim;

  assign link[0] = div_i;

  // one cell per quotient bit
  for (genvar i = 0; i < OB; i++) begin : g_cell
    tpi_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .div_i (link[i]),
      .div_o (link[i+1])
    );
  end

  assign last    = link[OB];
  assign neg_lim = {1'b1, {(OB-1){1'b0}}};

  // clip to the signed output range
  always_comb begin
    if (last.neg) begin
      if (last.ovf || last.quo > neg_lim) begin
        sat_o   = 1'b1;
        coord_o = neg_lim;
      end else begin
        sat_o   = 1'b0;
        coord_o = -last.quo;
      end
    end else begin
      if (last.ovf || last.quo[OB-1]) begin
        sat_o   = 1'b1;
        coord_o = ~neg_lim;
      end else begin
        sat_o   = 1'b0;
        coord_o = last.quo;
      end
    end
  end

endmodule

>>> rtl/core/three_plane_intersection_unit.sv
// throughput: one word per cycle, set by the fully pipelined divider rows
// (48 cells per coordinate, one quotient bit each) and the 5-stage front end
// the whole pipeline holds while the output register waits on out_ready_i
// reset clears all valid bits; the pipeline is empty and ready after reset
// ----------------------------------------------------------------------------
// three_plane_intersection_unit
// common point of three planes by cramer's rule, fixed point result
// ----------------------------------------------------------------------------
module three_plane_intersection_unit #(
  parameter int FRAC_BITS = tpi_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tpi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tpi_pkg::out_t out_data_o
);

  localparam int OB = tpi_pkg::OutBits;

  logic           en;
  tpi_pkg::meta_t meta_e;
  tpi_pkg::div_t  dx, dy, dz;
  logic [OB-1:0]  cx, cy, cz;
  logic           sx, sy, sz;
  logic [OB-1:0]  vld_q;
  logic [OB-1:0]  fnd_q;
  logic           out_valid_q;
  tpi_pkg::out_t  out_d, out_q;

  // global advance: hold only when the result is not taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  tpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .meta_o  (meta_e),
    .div_x_o (dx),
    .div_y_o (dy),
    .div_z_o (dz)
  );

  tpi_div_chain u_chain_x (.clk_i(clk_i), .en_i(en), .div_i(dx), .coord_o(cx), .sat_o(sx));
  tpi_div_chain u_chain_y (.clk_i(clk_i), .en_i(en), .div_i(dy), .coord_o(cy), .sat_o(sy));
  tpi_div_chain u_chain_z (.clk_i(clk_i), .en_i(en), .div_i(dz), .coord_o(cz), .sat_o(sz));

  // valid and found alongside the divider rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[OB-2:0], meta_e.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fnd_q <= {fnd_q[OB-2:0], meta_e.found};
    end
  end

  // result assembly
  always_comb begin
    out_d.found     = fnd_q[OB-1];
    out_d.point_x   = fnd_q[OB-1] ? cx : '0;
    out_d.point_y   = fnd_q[OB-1] ? cy : '0;
    out_d.point_z   = fnd_q[OB-1] ? cz : '0;
    out_d.saturated = fnd_q[OB-1] & (sx | sy | sz);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[OB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/tpi_checker.sv
// ----------------------------------------------------------------------------
// tpi_checker
// port-level checks of the three plane intersection unit
// ----------------------------------------------------------------------------
`include "three_plane_intersection_unit_defines.svh"

module tpi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input tpi_pkg::out_t out_data_o
);

  logic in_seen;
  logic lim_hit;

  assign in_seen = in_valid_i || !in_valid_i;
  assign lim_hit = (out_data_o.point_x == 48'h8000_0000_0000)
                || (out_data_o.point_x == 48'h7fff_ffff_ffff)
                || (out_data_o.point_y == 48'h8000_0000_0000)
                || (out_data_o.point_y == 48'h7fff_ffff_ffff)
                || (out_data_o.point_z == 48'h8000_0000_0000)
                || (out_data_o.point_z == 48'h7fff_ffff_ffff);

  // stalled result word holds
  `TPI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // pipeline stalls only on a waiting result
  `TPI_ASSERT(a_ready, clk_i, rst_ni, in_seen, in_ready_o == (!out_valid_o || out_ready_i))

  // no point means an all-zero word
  `TPI_ASSERT(a_not_found, clk_i, rst_ni, out_valid_o && !out_data_o.found, out_data_o.point_x == '0 && out_data_o.point_y == '0 && out_data_o.point_z == '0 && !out_data_o.saturated)

  // a clipped word shows at least one coordinate at a bound
  `TPI_ASSERT(a_sat_bound, clk_i, rst_ni, out_valid_o && out_data_o.saturated, lim_hit)

endmodule

bind three_plane_intersection_unit tpi_checker u_tpi_checker (.*);
